>>> src/bosw_pkg.sv
package bosw_pkg;

    localparam int C_PAGES   = 8;
    localparam int C_COLUMNS = 128;

    localparam logic [7:0] C_MASK_FULL = 8'hFF;
    localparam logic [7:0] C_MASK_TOP  = 8'h01;
    localparam logic [7:0] C_MASK_BOT  = 8'h80;

    typedef struct packed {
        logic [5:0] top_row;
        logic [6:0] left_column;
        logic [6:0] box_height;
        logic [7:0] box_width;
        logic [8:0] write_number;
    } t_in_item;

    typedef struct packed {
        logic [2:0] page_out;
        logic [6:0] column_out;
        logic [7:0] segment_mask;
        logic       final_write;
        logic       past_end;
        logic       off_screen;
    } t_out_item;

    // box geometry after the first stage
    typedef struct packed {
        logic [8:0] k;
        logic [6:0] lc;
        logic [7:0] w;
        logic [3:0] h_lo;
        logic [2:0] sp;
        logic [2:0] e;
        logic [4:0] np;
        logic [3:0] r;
        logic [9:0] count;
        logic       empty;
        logic       multi;
        logic       w_one;
    } t_geom;

    // selected write before the screen check
    typedef struct packed {
        logic [4:0] page;
        logic [8:0] col;
        logic [7:0] mask;
        logic       final_write;
        logic       past_end;
    } t_sel;

endpackage

>>> src/box_outline_segment_writer.sv
// a word taken on start is registered in the geometry, write select and screen check stages in turn
// throughput: one word per cycle, busy stays low; the three register stages
// (geometry, write select, screen check) never stall
// reset: synchronous active-low reset clears the stage valid bits only
// the receiver cannot stall, so every o_strobe cycle carries one result word
module box_outline_segment_writer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  bosw_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output bosw_pkg::t_out_item o_result
);

    logic                r_valid;
    bosw_pkg::t_out_item r_result;
    bosw_pkg::t_out_item n_result;
    logic                geom_valid;
    bosw_pkg::t_geom     geom;
    logic                sel_valid;
    bosw_pkg::t_sel      sel;

    bosw_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .o_valid (geom_valid),
        .o_geom  (geom)
    );

    bosw_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (geom_valid),
        .i_geom  (geom),
        .o_valid (sel_valid),
        .o_sel   (sel)
    );

    always_comb begin
        n_result.page_out     = sel.page[2:0];
        n_result.column_out   = sel.col[6:0];
        n_result.segment_mask = sel.mask;
        n_result.final_write  = sel.final_write;
        n_result.past_end     = sel.past_end;
        n_result.off_screen   = !sel.past_end
                              && ((sel.page >= 5'(bosw_pkg::C_PAGES))
                               || (sel.col >= 9'(bosw_pkg::C_COLUMNS)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= sel_valid;
        end
        r_result <= n_result;
    end

    assign busy     = 1'b0;
    assign o_strobe = r_valid;
    assign o_result = r_result;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##3 o_strobe)
        else $error("accepted word did not produce a result after three cycles");

    a_past_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.past_end) |-> (o_result.page_out == '0
            && o_result.column_out == '0 && o_result.segment_mask == '0
            && !o_result.final_write && !o_result.off_screen))
        else $error("past-end result carries nonzero fields");

    a_final_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.final_write && o_result.past_end))
        else $error("result flagged both final and past end");

    a_mask_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.past_end) |-> (o_result.segment_mask != '0))
        else $error("in-range write with empty segment mask");

endmodule

>>> src/bosw_geom.sv
module bosw_geom (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  bosw_pkg::t_in_item i_item,
    output logic              o_valid,
    output bosw_pkg::t_geom   o_geom
);

    logic            r_valid;
    bosw_pkg::t_geom r_geom;
    bosw_pkg::t_geom n_geom;
    logic [7:0]      span;

    always_comb begin
        // last row offset counted from the top of the first page
        span = 8'({5'd0, i_item.top_row[2:0]}) + {1'b0, i_item.box_height} - 8'd1;

        n_geom.k     = i_item.write_number;
        n_geom.lc    = i_item.left_column;
        n_geom.w     = i_item.box_width;
        n_geom.h_lo  = i_item.box_height[3:0];
        n_geom.sp    = i_item.top_row[5:3];
        n_geom.e     = i_item.top_row[2:0];
        n_geom.np    = span[7:3] + 5'd1;
        n_geom.r     = {1'b0, span[2:0]} + 4'd1;
        n_geom.empty = (i_item.box_height == '0) || (i_item.box_width == '0);
        n_geom.multi = (span[7:3] != '0);
        n_geom.w_one = (i_item.box_width == 8'd1);

        if (span[7:3] == '0) begin
            n_geom.count = {2'b00, i_item.box_width};
        end else if (i_item.box_width == 8'd1) begin
            n_geom.count = 10'(span[7:3]) + 10'd1;
        end else begin
            // 2*w + 2*(np-2) = 2*w + 2*(span/8 - 1)
            n_geom.count = {1'b0, i_item.box_width, 1'b0}
                         + {4'd0, span[7:3], 1'b0} - 10'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_geom <= n_geom;
    end

    assign o_valid = r_valid;
    assign o_geom  = r_geom;

endmodule

>>> src/bosw_select.sv
module bosw_select (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bosw_pkg::t_geom i_geom,
    output logic            o_valid,
    output bosw_pkg::t_sel  o_sel
);

    logic           r_valid;
    bosw_pkg::t_sel r_sel;
    bosw_pkg::t_sel n_sel;

    logic [9:0] kk;
    logic [9:0] w10;
    logic [9:0] mids;
    logic [9:0] j_mid;
    logic [9:0] j_bot;
    logic [7:0] top_corner;
    logic [7:0] top_mid;
    logic [7:0] bot_corner;
    logic [7:0] bot_mid;
    logic [7:0] one_corner;
    logic [7:0] one_mid;

    always_comb begin
        kk    = {1'b0, i_geom.k};
        w10   = {2'b00, i_geom.w};
        mids  = {4'd0, i_geom.np, 1'b0} - 10'd4;
        j_mid = kk - w10;
        j_bot = kk - w10 - mids;

        top_corner = 8'(bosw_pkg::C_MASK_FULL << i_geom.e);
        top_mid    = 8'(bosw_pkg::C_MASK_TOP << i_geom.e);
        bot_corner = bosw_pkg::C_MASK_FULL >> (4'd8 - i_geom.r);
        bot_mid    = bosw_pkg::C_MASK_BOT >> (4'd8 - i_geom.r);
        one_corner = 8'((bosw_pkg::C_MASK_FULL >> (4'd8 - i_geom.h_lo)) << i_geom.e);
        one_mid    = 8'((bosw_pkg::C_MASK_TOP
                       | 8'(bosw_pkg::C_MASK_TOP << (i_geom.h_lo - 4'd1))) << i_geom.e);

        n_sel.page        = {2'b00, i_geom.sp};
        n_sel.col         = {2'b00, i_geom.lc} + 9'(kk);
        n_sel.mask        = '0;
        n_sel.past_end    = i_geom.empty || (kk >= i_geom.count);
        n_sel.final_write = (kk == i_geom.count - 10'd1);

        if (!i_geom.multi) begin
            n_sel.mask = (kk == '0 || kk == w10 - 10'd1) ? one_corner : one_mid;
        end else if (i_geom.w_one) begin
            n_sel.page = {2'b00, i_geom.sp} + 5'(i_geom.k);
            n_sel.col  = {2'b00, i_geom.lc};
            if (kk == '0) begin
                n_sel.mask = top_corner;
            end else if (kk == 10'(i_geom.np) - 10'd1) begin
                n_sel.mask = bot_corner;
            end else begin
                n_sel.mask = bosw_pkg::C_MASK_FULL;
            end
        end else if (kk < w10) begin
            n_sel.mask = (kk == '0 || kk == w10 - 10'd1) ? top_corner : top_mid;
        end else if (kk < w10 + mids) begin
            // middle pages alternate left side, right side
            n_sel.page = {2'b00, i_geom.sp} + 5'd1 + 5'(j_mid[9:1]);
            n_sel.col  = j_mid[0] ? ({2'b00, i_geom.lc} + {1'b0, i_geom.w} - 9'd1)
                                  : {2'b00, i_geom.lc};
            n_sel.mask = bosw_pkg::C_MASK_FULL;
        end else begin
            n_sel.page = {2'b00, i_geom.sp} + i_geom.np - 5'd1;
            n_sel.col  = {2'b00, i_geom.lc} + 9'(j_bot);
            n_sel.mask = (j_bot == '0 || j_bot == w10 - 10'd1) ? bot_corner : bot_mid;
        end

        if (n_sel.past_end) begin
            n_sel.page        = '0;
            n_sel.col         = '0;
            n_sel.mask        = '0;
            n_sel.final_write = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_sel <= n_sel;
    end

    assign o_valid = r_valid;
    assign o_sel   = r_sel;

endmodule

>>> dv/tb_box_outline_segment_writer.sv
`timescale 1ns / 1ps

module tb_box_outline_segment_writer;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    bosw_pkg::t_in_item  i_item  = '0;
    logic                busy;
    logic                o_strobe;
    bosw_pkg::t_out_item o_result;

    box_outline_segment_writer i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // number of segment writes the box outline takes
    function automatic int unsigned box_write_total(bosw_pkg::t_in_item x);
        int unsigned e, h, w, np;
        e = x.top_row[2:0];
        h = x.box_height;
        w = x.box_width;
        if (h == 0 || w == 0) begin
            return 0;
        end
        np = ((e + h - 1) >> 3) + 1;
        if (np == 1) begin
            return w;
        end
        if (w == 1) begin
            return np;
        end
        return 2 * w + 2 * (np - 2);
    endfunction

    class segment_write_board;
        bosw_pkg::t_out_item expected_writes[$];
        int                  mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        function bosw_pkg::t_out_item predict_write(bosw_pkg::t_in_item x);
            int unsigned total, k, e, sp, h, w, lc, np, r, mids, j;
            int unsigned page, col, mask, corner, mid;
            int unsigned top_corner, top_mid, bot_corner, bot_mid;
            bosw_pkg::t_out_item y;
            y = '0;
            y.past_end = 1'b1;
            total = box_write_total(x);
            k = x.write_number;
            if (k >= total) begin
                return y;
            end
            e  = x.top_row[2:0];
            sp = x.top_row >> 3;
            h  = x.box_height;
            w  = x.box_width;
            lc = x.left_column;
            np = ((e + h - 1) >> 3) + 1;
            r  = ((e + h - 1) & 7) + 1;
            if (np > 1) begin
                top_corner = (32'(bosw_pkg::C_MASK_FULL) << e) & 32'hFF;
                top_mid    = (32'(bosw_pkg::C_MASK_TOP) << e) & 32'hFF;
                bot_corner = 32'(bosw_pkg::C_MASK_FULL) >> (8 - r);
                bot_mid    = 32'(bosw_pkg::C_MASK_BOT) >> (8 - r);
                mids       = 2 * (np - 2);
                if (w == 1) begin
                    page = sp + k;
                    col  = lc;
                    mask = (k == 0) ? top_corner :
                           (k == np - 1) ? bot_corner : 32'(bosw_pkg::C_MASK_FULL);
                end else if (k < w) begin
                    page = sp;
                    col  = lc + k;
                    mask = (k == 0 || k == w - 1) ? top_corner : top_mid;
                end else if (k < w + mids) begin
                    // side walls alternate left, right per middle page
                    j    = k - w;
                    page = sp + 1 + (j >> 1);
                    col  = j[0] ? lc + w - 1 : lc;
                    mask = 32'(bosw_pkg::C_MASK_FULL);
                end else begin
                    j    = k - w - mids;
                    page = sp + np - 1;
                    col  = lc + j;
                    mask = (j == 0 || j == w - 1) ? bot_corner : bot_mid;
                end
            end else begin
                corner = ((32'(bosw_pkg::C_MASK_FULL) >> (8 - h)) << e) & 32'hFF;
                mid    = ((32'(bosw_pkg::C_MASK_TOP)
                         | (32'(bosw_pkg::C_MASK_TOP) << (h - 1))) << e) & 32'hFF;
                page   = sp;
                col    = lc + k;
                mask   = (k == 0 || k == w - 1) ? corner : mid;
            end
            y.page_out     = 3'(page);
            y.column_out   = 7'(col);
            y.segment_mask = 8'(mask);
            y.final_write  = (k == total - 1);
            y.past_end     = 1'b0;
            y.off_screen   = (page >= bosw_pkg::C_PAGES || col >= bosw_pkg::C_COLUMNS);
            return y;
        endfunction

        function void note_word(bosw_pkg::t_in_item x);
            expected_writes.push_back(predict_write(x));
        endfunction

        task check_word(bosw_pkg::t_out_item got);
            bosw_pkg::t_out_item want;
            if (expected_writes.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = expected_writes.pop_front();
            if (got.page_out !== want.page_out) begin
                report($sformatf("page_out got %0d want %0d", got.page_out, want.page_out));
            end
            if (got.column_out !== want.column_out) begin
                report($sformatf("column_out got %0d want %0d",
                                 got.column_out, want.column_out));
            end
            if (got.segment_mask !== want.segment_mask) begin
                report($sformatf("segment_mask got %h want %h",
                                 got.segment_mask, want.segment_mask));
            end
            if (got.final_write !== want.final_write) begin
                report($sformatf("final_write got %b want %b",
                                 got.final_write, want.final_write));
            end
            if (got.past_end !== want.past_end) begin
                report($sformatf("past_end got %b want %b", got.past_end, want.past_end));
            end
            if (got.off_screen !== want.off_screen) begin
                report($sformatf("off_screen got %b want %b",
                                 got.off_screen, want.off_screen));
            end
        endtask
    endclass

    segment_write_board board = new();

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            board.check_word(o_result);
        end
    end

    function automatic bosw_pkg::t_in_item make_box(int unsigned row, int unsigned lc,
                                                    int unsigned h, int unsigned w,
                                                    int unsigned k);
        bosw_pkg::t_in_item x;
        x.top_row      = 6'(row);
        x.left_column  = 7'(lc);
        x.box_height   = 7'(h);
        x.box_width    = 8'(w);
        x.write_number = 9'(k);
        return x;
    endfunction

    // mostly legal boxes with write numbers near the valid range, some raw noise
    function automatic bosw_pkg::t_in_item random_box();
        int unsigned pick, total;
        bosw_pkg::t_in_item x;
        pick = $urandom_range(99);
        if (pick < 80) begin
            x.top_row     = 6'($urandom_range(63));
            x.left_column = 7'($urandom_range(127));
            x.box_height  = 7'($urandom_range(1) ? $urandom_range(1, 16) : $urandom_range(1, 64));
            x.box_width   = 8'($urandom_range(1) ? $urandom_range(1, 8) : $urandom_range(1, 128));
            total = box_write_total(x);
            pick = $urandom_range(9);
            x.write_number = 9'((pick == 0) ? total - 1 :
                                (pick == 1) ? total : $urandom_range(total - 1));
        end else begin
            x = bosw_pkg::t_in_item'(37'({$urandom, $urandom}));
        end
        return x;
    endfunction

    task drive_word(bosw_pkg::t_in_item x, int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= x;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        board.note_word(x);
    endtask

    task run_directed();
        bosw_pkg::t_in_item boxes[$];
        boxes.push_back(make_box(0, 0, 1, 1, 0));       // one pixel
        boxes.push_back(make_box(0, 10, 1, 5, 2));      // height one, middle column
        boxes.push_back(make_box(3, 4, 5, 4, 0));       // inside one page
        boxes.push_back(make_box(3, 4, 5, 4, 3));
        boxes.push_back(make_box(5, 20, 20, 1, 0));     // width one spanning pages
        boxes.push_back(make_box(5, 20, 20, 1, 1));
        boxes.push_back(make_box(5, 20, 20, 1, 3));
        boxes.push_back(make_box(5, 20, 20, 1, 4));
        boxes.push_back(make_box(0, 0, 64, 128, 0));    // full screen box
        boxes.push_back(make_box(0, 0, 64, 128, 127));
        boxes.push_back(make_box(0, 0, 64, 128, 128));
        boxes.push_back(make_box(0, 0, 64, 128, 129));
        boxes.push_back(make_box(0, 0, 64, 128, 267));
        boxes.push_back(make_box(0, 0, 64, 128, 268));
        boxes.push_back(make_box(7, 30, 2, 3, 3));      // two pages, no side walls
        boxes.push_back(make_box(7, 30, 2, 3, 5));
        boxes.push_back(make_box(9, 3, 0, 10, 0));      // zero height
        boxes.push_back(make_box(9, 3, 10, 0, 0));      // zero width
        boxes.push_back(make_box(63, 127, 127, 255, 0));    // oversized
        boxes.push_back(make_box(63, 127, 127, 255, 300));
        boxes.push_back(make_box(63, 127, 127, 255, 511));
        boxes.push_back(make_box(60, 120, 10, 20, 10)); // runs off the right edge
        boxes.push_back(make_box(0, 0, 8, 8, 511));     // past the end
        foreach (boxes[i]) begin
            drive_word(boxes[i], 21);
        end
    endtask

    initial begin
        int spins;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        repeat (530) drive_word(random_box(), 21);
        repeat (530) drive_word(random_box(), 75);
        repeat (530) drive_word(random_box(), 0);
        start <= 1'b0;
        spins = 0;
        while (board.expected_writes.size() != 0 && spins < 1000) begin
            @(posedge i_clk);
            spins++;
        end
        repeat (8) @(posedge i_clk);
        if (board.expected_writes.size() != 0) begin
            board.report($sformatf("%0d result words never came",
                                   board.expected_writes.size()));
        end
        if (board.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
